@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file.
// Each macro assumes clk_i and rst_ni are visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SRC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/src_pkg.sv @@
// Shared types and constants for the segment/rectangle clipper.
// No dependencies.
package src_pkg;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT
  } side_e;

  typedef struct packed {
    logic [1:0] count;
    side_e      first;
    side_e      second;
  } clip_ctl_t;

  localparam int CTL_W  = $bits(clip_ctl_t);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

endpackage

@@ hw/rtl/src_front.sv @@
// Front end: side tests, cross products and hit selection.
// Depends on src_pkg. Emits one packed queue entry per segment.
module src_front import src_pkg::*; #(
  parameter int W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic signed [W-1:0]    seg_start_x_i,
  input  logic signed [W-1:0]    seg_start_y_i,
  input  logic signed [W-1:0]    seg_end_x_i,
  input  logic signed [W-1:0]    seg_end_y_i,
  input  logic signed [W-1:0]    rect_left_i,
  input  logic signed [W-1:0]    rect_top_i,
  input  logic        [W-2:0]    rect_width_i,
  input  logic        [W-2:0]    rect_height_i,
  output logic                   push_o,
  input  logic                   q_ready_i,
  output logic [CTL_W+6*W+2*(2*W+1)+3:0] ent_o
);

  localparam int NW = 2 * W + 1;
  localparam int PW = 2 * W + 4;

  logic en;
  assign en      = !v2_q || q_ready_i;
  assign stall_o = !en;
  assign push_o  = v2_q && q_ready_i;

  // stage 1: per-side setup
  logic signed [W:0]   sxe, sye, exe, eye, lfe, tpe, rt, bt, dx, dy;
  logic signed [W:0]   c_a [4];
  logic signed [W:0]   lo_a [4];
  logic signed [W:0]   hi_a [4];
  logic signed [W:0]   dp_a [4];
  logic signed [W:0]   dq_a [4];
  logic signed [W-1:0] p0_a [4];
  logic signed [W-1:0] q0_a [4];

  logic signed [W+1:0] nn_d [4];
  logic        [W:0]   d_d  [4];
  logic signed [W+1:0] lq_d [4];
  logic signed [W+1:0] hq_d [4];
  logic                bad_d [4];
  logic                start_in;

  assign sxe = {seg_start_x_i[W-1], seg_start_x_i};
  assign sye = {seg_start_y_i[W-1], seg_start_y_i};
  assign exe = {seg_end_x_i[W-1], seg_end_x_i};
  assign eye = {seg_end_y_i[W-1], seg_end_y_i};
  assign lfe = {rect_left_i[W-1], rect_left_i};
  assign tpe = {rect_top_i[W-1], rect_top_i};
  assign rt  = lfe + $signed({2'b00, rect_width_i});
  assign bt  = tpe - $signed({2'b00, rect_height_i});
  assign dx  = exe - sxe;
  assign dy  = eye - sye;
  assign start_in = (sxe >= lfe) && (sxe <= rt) && (sye <= tpe) && (sye >= bt);

  always_comb begin
    c_a[SIDE_TOP]     = tpe;  lo_a[SIDE_TOP]    = lfe; hi_a[SIDE_TOP]    = rt;
    c_a[SIDE_RIGHT]   = rt;   lo_a[SIDE_RIGHT]  = bt;  hi_a[SIDE_RIGHT]  = tpe;
    c_a[SIDE_BOTTOM]  = bt;   lo_a[SIDE_BOTTOM] = lfe; hi_a[SIDE_BOTTOM] = rt;
    c_a[SIDE_LEFT]    = lfe;  lo_a[SIDE_LEFT]   = bt;  hi_a[SIDE_LEFT]   = tpe;
    // horizontal sides cross in x, vertical ones in y
    dp_a[SIDE_TOP]    = dy; dq_a[SIDE_TOP]    = dx;
    p0_a[SIDE_TOP]    = seg_start_y_i; q0_a[SIDE_TOP]    = seg_start_x_i;
    dp_a[SIDE_BOTTOM] = dy; dq_a[SIDE_BOTTOM] = dx;
    p0_a[SIDE_BOTTOM] = seg_start_y_i; q0_a[SIDE_BOTTOM] = seg_start_x_i;
    dp_a[SIDE_RIGHT]  = dx; dq_a[SIDE_RIGHT]  = dy;
    p0_a[SIDE_RIGHT]  = seg_start_x_i; q0_a[SIDE_RIGHT]  = seg_start_y_i;
    dp_a[SIDE_LEFT]   = dx; dq_a[SIDE_LEFT]   = dy;
    p0_a[SIDE_LEFT]   = seg_start_x_i; q0_a[SIDE_LEFT]   = seg_start_y_i;
  end

  always_comb begin
    logic signed [W+1:0] n_tmp;
    n_tmp = '0;
    for (int s = 0; s < 4; s++) begin
      n_tmp    = {c_a[s][W], c_a[s]} - {{2{p0_a[s][W-1]}}, p0_a[s]};
      nn_d[s]  = dp_a[s][W] ? -n_tmp : n_tmp;
      d_d[s]   = dp_a[s][W] ? -dp_a[s] : dp_a[s];
      lq_d[s]  = {lo_a[s][W], lo_a[s]} - {{2{q0_a[s][W-1]}}, q0_a[s]};
      hq_d[s]  = {hi_a[s][W], hi_a[s]} - {{2{q0_a[s][W-1]}}, q0_a[s]};
      bad_d[s] = (dp_a[s] == '0) || (hi_a[s] == lo_a[s]) || nn_d[s][W+1] ||
                 (nn_d[s] > $signed({1'b0, d_d[s]}));
    end
  end

  logic                v1_q, v2_q;
  logic signed [W+1:0] nn1_q [4];
  logic        [W:0]   d1_q  [4];
  logic signed [W+1:0] lq1_q [4];
  logic signed [W+1:0] hq1_q [4];
  logic signed [W:0]   dq1_q [4];
  logic signed [W-1:0] q01_q [4];
  logic signed [W:0]   c1_q  [4];
  logic                bad1_q [4];
  logic signed [W-1:0] ax1_q, ay1_q;

  // stage 2: products
  logic signed [PW-1:0] pr2_q [4];
  logic signed [PW-1:0] pl2_q [4];
  logic signed [PW-1:0] ph2_q [4];
  logic signed [PW-1:0] pq2_q [4];
  logic                 bad2_q [4];
  logic signed [W:0]    c2_q  [4];
  logic        [W:0]    d2_q  [4];
  logic signed [W-1:0]  ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 4; s++) begin
        nn1_q[s]  <= nn_d[s];
        d1_q[s]   <= d_d[s];
        lq1_q[s]  <= lq_d[s];
        hq1_q[s]  <= hq_d[s];
        dq1_q[s]  <= dq_a[s];
        q01_q[s]  <= q0_a[s];
        c1_q[s]   <= c_a[s];
        bad1_q[s] <= bad_d[s];
        pr2_q[s]  <= PW'(dq1_q[s]) * PW'(nn1_q[s]);
        pl2_q[s]  <= PW'(lq1_q[s]) * PW'($signed({1'b0, d1_q[s]}));
        ph2_q[s]  <= PW'(hq1_q[s]) * PW'($signed({1'b0, d1_q[s]}));
        pq2_q[s]  <= PW'(q01_q[s]) * PW'($signed({1'b0, d1_q[s]}));
        bad2_q[s] <= bad1_q[s];
        c2_q[s]   <= c1_q[s];
        d2_q[s]   <= d1_q[s];
      end
      ax1_q <= start_in ? seg_start_x_i : seg_end_x_i;
      ay1_q <= start_in ? seg_start_y_i : seg_end_y_i;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
    end
  end

  // stage 3: hit test, pick the first two hits in side order
  logic          hit [4];
  logic [NW-1:0] mag [4];
  logic          neg [4];
  clip_ctl_t     ctl;
  logic [1:0]    sel0, sel1;
  logic [W-1:0]  c0, c1;
  logic [NW-1:0] m0, m1;
  logic          n0, n1;
  logic [W:0]    d0, d1;

  always_comb begin
    logic signed [PW-1:0] num;
    num = '0;
    for (int s = 0; s < 4; s++) begin
      hit[s] = !bad2_q[s] && (pr2_q[s] >= pl2_q[s]) && (pr2_q[s] <= ph2_q[s]);
      num    = pq2_q[s] + pr2_q[s];
      neg[s] = num[PW-1];
      mag[s] = NW'(num[PW-1] ? -num : num);
    end
  end

  always_comb begin
    ctl  = '{count: 2'd0, first: SIDE_TOP, second: SIDE_TOP};
    sel0 = '0;
    sel1 = '0;
    for (int s = 0; s < 4; s++) begin
      if (hit[s]) begin
        if (ctl.count == 2'd0) begin
          sel0      = 2'(s);
          ctl.count = 2'd1;
        end else if (ctl.count == 2'd1) begin
          sel1      = 2'(s);
          ctl.count = 2'd2;
        end
      end
    end
    // unused lanes divide zero by one so they come out as zero
    c0 = '0; m0 = '0; n0 = 1'b0; d0 = (W+1)'(1);
    c1 = '0; m1 = '0; n1 = 1'b0; d1 = (W+1)'(1);
    if (ctl.count != 2'd0) begin
      ctl.first = side_e'(sel0);
      c0 = c2_q[sel0][W-1:0]; m0 = mag[sel0]; n0 = neg[sel0]; d0 = d2_q[sel0];
    end
    if (ctl.count == 2'd2) begin
      ctl.second = side_e'(sel1);
      c1 = c2_q[sel1][W-1:0]; m1 = mag[sel1]; n1 = neg[sel1]; d1 = d2_q[sel1];
    end
  end

  assign ent_o = {ctl, c0, c1, m0, m1, n0, n1, d0, d1, ax2_q, ay2_q};

endmodule

@@ hw/rtl/src_fifo.sv @@
// Small register FIFO between the front and back ends.
// Depends on src_pkg for its depth.
module src_fifo import src_pkg::*; #(
  parameter int EW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [EW-1:0] data_i,
  output logic          ready_o,
  output logic          valid_o,
  output logic [EW-1:0] data_o,
  input  logic          pop_i
);

  logic [EW-1:0]     mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign ready_o = cnt_q != (QPTR_W+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

@@ hw/rtl/src_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies. Quotient magnitude must fit W bits.
module src_div #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*W:0]        num_i,
  input  logic [W:0]          den_i,
  input  logic                neg_i,
  output logic signed [W-1:0] quot_o
);

  logic [W:0]   rem_q  [W+1];
  logic [W-1:0] low_q  [W+1];
  logic [W-1:0] quot_q [W+1];
  logic [W:0]   den_q  [W+1];
  logic         neg_q  [W+1];

  always_ff @(posedge clk_i) begin
    logic [W+1:0] t;
    logic         ge;
    if (en_i) begin
      rem_q[0]  <= num_i[2*W:W];
      low_q[0]  <= num_i[W-1:0];
      quot_q[0] <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      for (int j = 0; j < W; j++) begin
        t  = {rem_q[j], low_q[j][W-1]};
        ge = t >= {1'b0, den_q[j]};
        rem_q[j+1]  <= ge ? (W+1)'(t - {1'b0, den_q[j]}) : t[W:0];
        low_q[j+1]  <= {low_q[j][W-2:0], 1'b0};
        quot_q[j+1] <= {quot_q[j][W-2:0], ge};
        den_q[j+1]  <= den_q[j];
        neg_q[j+1]  <= neg_q[j];
      end
    end
  end

  assign quot_o = neg_q[W] ? -$signed(quot_q[W]) : $signed(quot_q[W]);

endmodule

@@ hw/rtl/src_back.sv @@
// Back end: divides out the crossing coordinates and forms the result.
// Depends on src_pkg and src_div.
module src_back import src_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [CTL_W+6*W+2*(2*W+1)+3:0] ent_i,
  output logic                q_pop_o,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [1:0]          hit_count_o,
  output logic [1:0]          first_side_o,
  output logic [1:0]          second_side_o,
  output logic signed [W-1:0] clip_start_x_o,
  output logic signed [W-1:0] clip_start_y_o,
  output logic signed [W-1:0] clip_end_x_o,
  output logic signed [W-1:0] clip_end_y_o
);

  localparam int NW = 2 * W + 1;

  clip_ctl_t     ctl;
  logic [W-1:0]  c0, c1, ax, ay;
  logic [NW-1:0] m0, m1;
  logic          n0, n1;
  logic [W:0]    d0, d1;

  assign {ctl, c0, c1, m0, m1, n0, n1, d0, d1, ax, ay} = ent_i;

  logic en, valid_q;
  assign en      = !valid_q || !stall_i;
  assign q_pop_o = en && q_valid_i;
  assign valid_o = valid_q;

  logic signed [W-1:0] qt0, qt1;

  src_div #(.W(W)) u_div0 (
    .clk_i, .en_i(en), .num_i(m0), .den_i(d0), .neg_i(n0), .quot_o(qt0)
  );
  src_div #(.W(W)) u_div1 (
    .clk_i, .en_i(en), .num_i(m1), .den_i(d1), .neg_i(n1), .quot_o(qt1)
  );

  // sideband tracks the divider stages
  logic                sb_v_q   [W+1];
  clip_ctl_t           sb_ctl_q [W+1];
  logic signed [W-1:0] sb_c0_q  [W+1];
  logic signed [W-1:0] sb_c1_q  [W+1];
  logic signed [W-1:0] sb_ax_q  [W+1];
  logic signed [W-1:0] sb_ay_q  [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= W; j++) sb_v_q[j] <= 1'b0;
      valid_q <= 1'b0;
    end else if (en) begin
      sb_v_q[0] <= q_valid_i;
      for (int j = 0; j < W; j++) sb_v_q[j+1] <= sb_v_q[j];
      valid_q <= sb_v_q[W];
    end
  end

  clip_ctl_t           oc;
  logic                hz0, hz1;
  logic signed [W-1:0] x0, y0, x1, y1;

  assign oc  = sb_ctl_q[W];
  assign hz0 = (oc.first == SIDE_TOP) || (oc.first == SIDE_BOTTOM);
  assign hz1 = (oc.second == SIDE_TOP) || (oc.second == SIDE_BOTTOM);

  always_comb begin
    x0 = hz0 ? qt0 : sb_c0_q[W];
    y0 = hz0 ? sb_c0_q[W] : qt0;
    if (oc.count == 2'd1) begin
      x1 = sb_ax_q[W];
      y1 = sb_ay_q[W];
    end else begin
      x1 = hz1 ? qt1 : sb_c1_q[W];
      y1 = hz1 ? sb_c1_q[W] : qt1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_ctl_q[0] <= ctl;
      sb_c0_q[0]  <= c0;
      sb_c1_q[0]  <= c1;
      sb_ax_q[0]  <= ax;
      sb_ay_q[0]  <= ay;
      for (int j = 0; j < W; j++) begin
        sb_ctl_q[j+1] <= sb_ctl_q[j];
        sb_c0_q[j+1]  <= sb_c0_q[j];
        sb_c1_q[j+1]  <= sb_c1_q[j];
        sb_ax_q[j+1]  <= sb_ax_q[j];
        sb_ay_q[j+1]  <= sb_ay_q[j];
      end
      hit_count_o    <= oc.count;
      first_side_o   <= oc.first;
      second_side_o  <= oc.second;
      clip_start_x_o <= x0;
      clip_start_y_o <= y0;
      clip_end_x_o   <= x1;
      clip_end_y_o   <= y1;
    end
  end

endmodule

@@ hw/rtl/segment_rect_clip.sv @@
// Top level of the segment/rectangle clipper.
// Depends on src_pkg, src_front, src_fifo and src_back.
//
// Clips a segment against an axis-aligned rectangle (top-left corner, width,
// height, y up) in signed Q16.16 and reports up to two crossed sides, in the
// order top, right, bottom, left, with the crossing points truncated toward
// zero. One segment is accepted every cycle while stall_o is low. A result
// passes through the two front stages, the queue and the COORD_WIDTH + 1
// stage divider of the back end, then through its output register.
// A four-entry queue separates the two halves, so output stalls reach the
// input only once it fills.
module segment_rect_clip import src_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] rect_left_i,
  input  logic signed [COORD_WIDTH-1:0] rect_top_i,
  input  logic        [COORD_WIDTH-2:0] rect_width_i,
  input  logic        [COORD_WIDTH-2:0] rect_height_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [1:0]                    hit_count_o,
  output logic [1:0]                    first_side_o,
  output logic [1:0]                    second_side_o,
  output logic signed [COORD_WIDTH-1:0] clip_start_x_o,
  output logic signed [COORD_WIDTH-1:0] clip_start_y_o,
  output logic signed [COORD_WIDTH-1:0] clip_end_x_o,
  output logic signed [COORD_WIDTH-1:0] clip_end_y_o
);

  localparam int EW = CTL_W + 6*COORD_WIDTH + 2*(2*COORD_WIDTH+1) + 4;

  logic          push, q_ready, q_valid, q_pop;
  logic [EW-1:0] ent_in, ent_out;

  src_front #(.W(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .seg_start_x_i, .seg_start_y_i, .seg_end_x_i, .seg_end_y_i,
    .rect_left_i, .rect_top_i, .rect_width_i, .rect_height_i,
    .push_o(push), .q_ready_i(q_ready), .ent_o(ent_in)
  );

  src_fifo #(.EW(EW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(ent_in), .ready_o(q_ready),
    .valid_o(q_valid), .data_o(ent_out), .pop_i(q_pop)
  );

  src_back #(.W(COORD_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .ent_i(ent_out), .q_pop_o(q_pop),
    .valid_o, .stall_i, .hit_count_o, .first_side_o, .second_side_o,
    .clip_start_x_o, .clip_start_y_o, .clip_end_x_o, .clip_end_y_o
  );

endmodule

@@ hw/rtl/src_checker.sv @@
// Port-level checker for segment_rect_clip, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module src_checker #(
  parameter int W = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         valid_i,
  input logic         stall_o,
  input logic         valid_o,
  input logic         stall_i,
  input logic [1:0]   hit_count_o,
  input logic [1:0]   first_side_o,
  input logic [1:0]   second_side_o,
  input logic [W-1:0] clip_start_x_o,
  input logic [W-1:0] clip_start_y_o,
  input logic [W-1:0] clip_end_x_o,
  input logic [W-1:0] clip_end_y_o
);

  `SRC_ASSERT(a_count_range, valid_o, hit_count_o != 2'd3, "hit count above two")
  `SRC_ASSERT(a_miss_zero, valid_o && hit_count_o == 2'd0,
              first_side_o == 2'd0 && second_side_o == 2'd0 &&
              clip_start_x_o == '0 && clip_start_y_o == '0 &&
              clip_end_x_o == '0 && clip_end_y_o == '0, "miss with nonzero fields")
  `SRC_ASSERT(a_second_side, valid_o && hit_count_o != 2'd2,
              second_side_o == 2'd0, "second side set without second hit")
  `SRC_ASSERT_NXT(a_hold, valid_o && stall_i,
                  valid_o && $stable(hit_count_o) && $stable(clip_start_x_o) &&
                  $stable(clip_end_y_o), "stalled result changed")

endmodule

bind segment_rect_clip src_checker #(.W(COORD_WIDTH)) u_src_checker (.*);
